>>> rtl/swept_segment_intersection_top_macros.svh
// Assertion macros for the swept segment intersection checker.
`ifndef SWEPT_SEGMENT_INTERSECTION_TOP_MACROS_SVH
`define SWEPT_SEGMENT_INTERSECTION_TOP_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define SSI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swept segment intersection check failed");

// Implication checked on every clock edge, reset included.
`define SSI_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("swept segment intersection check failed");

`endif

>>> rtl/ssi_pkg.sv
// Shared widths and types for the swept segment intersection block.
`timescale 1ns / 1ps
package ssi_pkg;
    localparam int COORD_W = 24;
    localparam int TIME_W  = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int CROSS_W = 51;
    localparam int NUM_W   = CROSS_W - 1;
    localparam int QUO_W   = 32;

    // Data that rides alongside the divider.
    typedef struct packed {
        logic signed [COORD_W-1:0] mx;
        logic signed [COORD_W-1:0] my;
        logic                      cond;
        logic                      eq;
    } t_side;
endpackage

>>> rtl/ssi_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module ssi_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [ssi_pkg::NUM_W-1:0]     i_num,
    input  logic [ssi_pkg::NUM_W-1:0]     i_den,
    input  ssi_pkg::t_side                i_side,
    output logic                          o_valid,
    output logic [ssi_pkg::QUO_W-1:0]     o_quo,
    output ssi_pkg::t_side                o_side
);
    localparam int N = ssi_pkg::QUO_W;
    localparam int W = ssi_pkg::NUM_W;

    logic           r_vld [N+1];
    logic [W-1:0]   r_rem [N+1];
    logic [W-1:0]   r_den [N+1];
    logic [N-1:0]   r_quo [N+1];
    ssi_pkg::t_side r_side[N+1];

    always_comb begin
        r_vld[0]  = i_valid;
        r_rem[0]  = i_num;
        r_den[0]  = i_den;
        r_quo[0]  = '0;
        r_side[0] = i_side;
    end

    for (genvar g = 0; g < N; g++) begin : g_step
        logic [W:0] n_shift;
        logic [W:0] n_diff;
        logic       n_bit;
        always_comb begin
            n_shift = {r_rem[g], 1'b0};
            n_diff  = n_shift - {1'b0, r_den[g]};
            n_bit   = (n_shift >= {1'b0, r_den[g]});
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[g+1] <= r_vld[g];
            end
            if (i_en) begin
                r_rem[g+1]  <= n_bit ? n_diff[W-1:0] : n_shift[W-1:0];
                r_den[g+1]  <= r_den[g];
                r_quo[g+1]  <= {r_quo[g][N-2:0], n_bit};
                r_side[g+1] <= r_side[g];
            end
        end
    end

    assign o_valid = r_vld[N];
    assign o_quo   = r_quo[N];
    assign o_side  = r_side[N];
endmodule

>>> rtl/swept_segment_intersection_top.sv
// Top level of the swept segment intersection pipeline.
//
//  Channel   Direction  Handshake               Payload
//  input     in         i_valid / o_ready       pos, vel, wall start, wall end
//  result    out        o_valid / i_ready       offset_x, offset_y, hit
//  config    in         i_cfg_valid / o_cfg_ready   cfg_data (frame time, Q0.16)
//
// A beat may enter in every cycle in which the output does not stall the
// pipeline. It passes through 39 register stages, set by the 32 stage quotient
// pipeline plus seven arithmetic stages. The whole pipeline advances together
// whenever the output register is empty or its beat is being taken, so a stall
// at the output holds every stage and nothing is lost or repeated. Reset clears
// every valid bit and sets the frame time to zero. The configuration port is
// always ready.
`timescale 1ns / 1ps
module swept_segment_intersection_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [ssi_pkg::COORD_W-1:0]   i_pos_x,
    input  logic signed [ssi_pkg::COORD_W-1:0]   i_pos_y,
    input  logic signed [ssi_pkg::COORD_W-1:0]   i_vel_x,
    input  logic signed [ssi_pkg::COORD_W-1:0]   i_vel_y,
    input  logic signed [ssi_pkg::COORD_W-1:0]   i_wall_start_x,
    input  logic signed [ssi_pkg::COORD_W-1:0]   i_wall_start_y,
    input  logic signed [ssi_pkg::COORD_W-1:0]   i_wall_end_x,
    input  logic signed [ssi_pkg::COORD_W-1:0]   i_wall_end_y,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [ssi_pkg::COORD_W-1:0]   o_offset_x,
    output logic signed [ssi_pkg::COORD_W-1:0]   o_offset_y,
    output logic                                 o_hit,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [ssi_pkg::TIME_W-1:0]           i_cfg_data
);
    localparam int CW  = ssi_pkg::COORD_W;
    localparam int TW  = ssi_pkg::TIME_W;
    localparam int DW  = ssi_pkg::DIFF_W;
    localparam int XW  = ssi_pkg::CROSS_W;
    localparam int NW  = ssi_pkg::NUM_W;
    localparam int QW  = ssi_pkg::QUO_W;
    localparam int SW  = CW + TW;        // scaled velocity magnitude
    localparam int PW  = CW + QW;        // clipped product width

    logic en;
    logic r_out_vld;

    // The pipeline moves as one: it may advance if the output is free or taken.
    assign en          = !r_out_vld || i_ready;
    assign o_ready     = en;
    assign o_cfg_ready = 1'b1;

    logic [TW-1:0] r_frame_time;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_time <= '0;
        end else if (i_cfg_valid) begin
            r_frame_time <= i_cfg_data;
        end
    end

    // Stage 1: velocity magnitudes times frame time, wall and offset differences.
    logic                 r1_vld, r1_sx, r1_sy;
    logic [SW-1:0]        r1_magx, r1_magy;
    logic signed [DW-1:0] r1_wdx, r1_wdy, r1_dx, r1_dy;
    logic [CW-1:0]        n_absx, n_absy;

    assign n_absx = i_vel_x[CW-1] ? CW'(-i_vel_x) : CW'(i_vel_x);
    assign n_absy = i_vel_y[CW-1] ? CW'(-i_vel_y) : CW'(i_vel_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_valid;
        end
        if (en) begin
            r1_sx   <= i_vel_x[CW-1];
            r1_sy   <= i_vel_y[CW-1];
            r1_magx <= SW'(n_absx) * SW'(r_frame_time);
            r1_magy <= SW'(n_absy) * SW'(r_frame_time);
            r1_wdx  <= DW'(i_wall_end_x) - DW'(i_wall_start_x);
            r1_wdy  <= DW'(i_wall_end_y) - DW'(i_wall_start_y);
            r1_dx   <= DW'(i_wall_start_x) - DW'(i_pos_x);
            r1_dy   <= DW'(i_wall_start_y) - DW'(i_pos_y);
        end
    end

    // Stage 2: round the motion to nearest, ties away from zero, and sign it.
    logic                 r2_vld;
    logic signed [CW-1:0] r2_mx, r2_my;
    logic signed [DW-1:0] r2_wdx, r2_wdy, r2_dx, r2_dy;
    logic [SW-1:0]        n_rndx, n_rndy;

    assign n_rndx = r1_magx + SW'(1 << (TW - 1));
    assign n_rndy = r1_magy + SW'(1 << (TW - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
        if (en) begin
            r2_mx  <= r1_sx ? -$signed(n_rndx[SW-1:TW]) : $signed(n_rndx[SW-1:TW]);
            r2_my  <= r1_sy ? -$signed(n_rndy[SW-1:TW]) : $signed(n_rndy[SW-1:TW]);
            r2_wdx <= r1_wdx;
            r2_wdy <= r1_wdy;
            r2_dx  <= r1_dx;
            r2_dy  <= r1_dy;
        end
    end

    // Stage 3: the six products of the three cross products.
    logic                 r3_vld;
    logic signed [CW-1:0] r3_mx, r3_my;
    logic signed [XW-1:0] r3_b0, r3_b1, r3_a0, r3_a1, r3_c0, r3_c1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
        if (en) begin
            r3_mx <= r2_mx;
            r3_my <= r2_my;
            r3_b0 <= XW'(r2_wdx) * XW'(r2_my);
            r3_b1 <= XW'(r2_wdy) * XW'(r2_mx);
            r3_a0 <= XW'(r2_wdx) * XW'(r2_dy);
            r3_a1 <= XW'(r2_wdy) * XW'(r2_dx);
            r3_c0 <= XW'(r2_mx) * XW'(r2_dy);
            r3_c1 <= XW'(r2_my) * XW'(r2_dx);
        end
    end

    // Stage 4: differences, then flip all three so that b is not negative.
    logic                 r4_vld;
    logic signed [CW-1:0] r4_mx, r4_my;
    logic signed [XW-1:0] r4_a, r4_b, r4_c;
    logic signed [XW-1:0] n_a, n_b, n_c;
    logic                 n_neg;

    assign n_b   = r3_b0 - r3_b1;
    assign n_a   = r3_a0 - r3_a1;
    assign n_c   = r3_c0 - r3_c1;
    assign n_neg = n_b[XW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= r3_vld;
        end
        if (en) begin
            r4_mx <= r3_mx;
            r4_my <= r3_my;
            r4_a  <= n_neg ? -n_a : n_a;
            r4_b  <= n_neg ? -n_b : n_b;
            r4_c  <= n_neg ? -n_c : n_c;
        end
    end

    // Stage 5: range test. Touching either end of either segment is a hit.
    logic           r5_vld;
    logic [NW-1:0]  r5_num, r5_den;
    ssi_pkg::t_side r5_side;
    logic           n_cond;

    assign n_cond = (r4_b != '0) && !r4_a[XW-1] && (r4_a <= r4_b)
                 && !r4_c[XW-1] && (r4_c <= r4_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (en) begin
            r5_vld <= r4_vld;
        end
        if (en) begin
            r5_num       <= r4_a[NW-1:0];
            r5_den       <= r4_b[NW-1:0];
            r5_side.mx   <= r4_mx;
            r5_side.my   <= r4_my;
            r5_side.cond <= n_cond;
            r5_side.eq   <= (r4_a == r4_b);
        end
    end

    // Alpha as an unsigned Q0.32 fraction; alpha of one is carried as eq.
    logic           div_vld;
    logic [QW-1:0]  div_quo;
    ssi_pkg::t_side div_side;

    ssi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r5_vld),
        .i_num   (r5_num),
        .i_den   (r5_den),
        .i_side  (r5_side),
        .o_valid (div_vld),
        .o_quo   (div_quo),
        .o_side  (div_side)
    );

    // Clip stage 1: motion magnitudes times alpha.
    logic           r6_vld;
    logic [PW-1:0]  r6_px, r6_py;
    ssi_pkg::t_side r6_side;
    logic [CW-1:0]  n_mmx, n_mmy;

    assign n_mmx = div_side.mx[CW-1] ? CW'(-div_side.mx) : CW'(div_side.mx);
    assign n_mmy = div_side.my[CW-1] ? CW'(-div_side.my) : CW'(div_side.my);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (en) begin
            r6_vld <= div_vld;
        end
        if (en) begin
            r6_px   <= PW'(n_mmx) * PW'(div_quo);
            r6_py   <= PW'(n_mmy) * PW'(div_quo);
            r6_side <= div_side;
        end
    end

    // Clip stage 2: round, restore sign, choose clipped or full motion.
    // The clipped magnitude never exceeds the motion, so no saturation is needed.
    logic [PW-1:0]        n_rx, n_ry;
    logic signed [CW-1:0] n_cx, n_cy;
    logic signed [CW-1:0] r_off_x, r_off_y;
    logic                 r_hit;

    assign n_rx = r6_px + PW'(64'd1 << (QW - 1));
    assign n_ry = r6_py + PW'(64'd1 << (QW - 1));
    assign n_cx = r6_side.mx[CW-1] ? -$signed(n_rx[PW-1:QW]) : $signed(n_rx[PW-1:QW]);
    assign n_cy = r6_side.my[CW-1] ? -$signed(n_ry[PW-1:QW]) : $signed(n_ry[PW-1:QW]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r6_vld;
        end
        if (en) begin
            if (r6_side.cond && !r6_side.eq) begin
                r_off_x <= n_cx;
                r_off_y <= n_cy;
            end else begin
                r_off_x <= r6_side.mx;
                r_off_y <= r6_side.my;
            end
            r_hit <= r6_side.cond;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_offset_x = r_off_x;
    assign o_offset_y = r_off_y;
    assign o_hit      = r_hit;
endmodule

>>> rtl/ssi_checker.sv
// Port-level checker for the swept segment intersection block, with its bind.
`timescale 1ns / 1ps
`include "swept_segment_intersection_top_macros.svh"
module ssi_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_ready,
    input logic                               o_valid,
    input logic                               i_ready,
    input logic signed [ssi_pkg::COORD_W-1:0] o_offset_x,
    input logic signed [ssi_pkg::COORD_W-1:0] o_offset_y,
    input logic                               o_hit
);
    // A held result keeps its value while the consumer stalls.
    `SSI_ASSERT_IMPL(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable({o_offset_x, o_offset_y, o_hit}))
    // A full, stalled pipeline takes no new beat.
    `SSI_ASSERT_IMPL(a_backpressure, i_clk, i_rst_n, 1'b1, !($past(o_valid) && !$past(i_ready)) || !$past(o_ready))
    // Reset empties the output register.
    `SSI_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_valid)
endmodule

bind swept_segment_intersection_top ssi_checker u_ssi_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_offset_x (o_offset_x),
    .o_offset_y (o_offset_y),
    .o_hit      (o_hit)
);

>>> tb/swept_segment_intersection_top_tb.sv
// Self-checking testbench for the swept segment intersection pipeline.
`timescale 1ns / 1ps
module swept_segment_intersection_top_tb;
    localparam int COORD_W     = ssi_pkg::COORD_W;
    localparam int TIME_W      = ssi_pkg::TIME_W;
    localparam int LATENCY     = 40;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic signed [COORD_W-1:0] px, py, vx, vy, w0x, w0y, w1x, w1y;
    } t_probe;

    typedef struct {
        logic signed [COORD_W-1:0] ox, oy;
        logic                      hit;
    } t_offset;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic signed [COORD_W-1:0] i_pos_x = '0, i_pos_y = '0, i_vel_x = '0, i_vel_y = '0;
    logic signed [COORD_W-1:0] i_wall_start_x = '0, i_wall_start_y = '0;
    logic signed [COORD_W-1:0] i_wall_end_x = '0, i_wall_end_y = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [COORD_W-1:0] o_offset_x, o_offset_y;
    logic o_hit;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [TIME_W-1:0] i_cfg_data = '0;

    // The predictor's own copy of the frame time register.
    logic [TIME_W-1:0] step_time = '0;

    t_offset expected_offsets[$];
    int  mismatches = 0;
    int  results_seen = 0;
    int  hits_seen = 0;
    int  beats_sent = 0;
    longint cycles = 0;

    // Idle percentages for each side, and a long hold on the result side.
    int  send_idle_pct = 0;
    int  take_idle_pct = 0;
    int  hold_cycles = 0;

    swept_segment_intersection_top u_top (.*);

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Cycle counter; the limit is far beyond the slowest legitimate run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("swept_segment_intersection_top test failed");
            $finish;
        end
    end

    // Scale one velocity component by the frame time, rounding the magnitude
    // to nearest with ties away from zero.
    function automatic longint motion_of(logic signed [COORD_W-1:0] v);
        longint mag;
        longint r;
        mag = (v < 0) ? -longint'(v) : longint'(v);
        r = (mag * longint'(step_time) + 64'h8000) >>> 16;
        return (v < 0) ? -r : r;
    endfunction

    // Clip a motion component by the Q0.32 fraction alpha.
    function automatic longint clipped(longint m, logic [63:0] alpha);
        logic [127:0] prod;
        longint r;
        prod = 128'(m < 0 ? -m : m) * 128'(alpha) + 128'h8000_0000;
        r = longint'(prod >> 32);
        return (m < 0) ? -r : r;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_coord(longint v);
        if (v > 8388607) return 24'sh7fffff;
        if (v < -8388608) return 24'sh800000;
        return v[COORD_W-1:0];
    endfunction

    function automatic t_offset predict_offset(t_probe p);
        longint mx, my, wdx, wdy, dx, dy, a, b, c, ox, oy;
        logic [63:0] alpha;
        t_offset res;
        mx = motion_of(p.vx);
        my = motion_of(p.vy);
        wdx = longint'(p.w1x) - longint'(p.w0x);
        wdy = longint'(p.w1y) - longint'(p.w0y);
        dx = longint'(p.w0x) - longint'(p.px);
        dy = longint'(p.w0y) - longint'(p.py);
        b = wdx * my - wdy * mx;
        a = wdx * dy - wdy * dx;
        c = mx * dy - my * dx;
        ox = mx;
        oy = my;
        res.hit = 1'b0;
        if (b != 0) begin
            if (b < 0) begin
                a = -a; b = -b; c = -c;
            end
            if (a >= 0 && a <= b && c >= 0 && c <= b) begin
                // Exact quotient; the products stay well inside 64 bits.
                if (a >= b) alpha = 64'h1_0000_0000;
                else alpha = 64'((128'(a) << 32) / 128'(b));
                ox = clipped(mx, alpha);
                oy = clipped(my, alpha);
                res.hit = 1'b1;
            end
        end
        res.ox = sat_coord(ox);
        res.oy = sat_coord(oy);
        return res;
    endfunction

    // Result side: ready toggles at the falling edge, and the beat is checked
    // at the rising edge where valid and ready are both high.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            i_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_offset exp_off;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (o_hit) hits_seen++;
            if (expected_offsets.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %0d %0d hit %0b",
                             o_offset_x, o_offset_y, o_hit);
            end else begin
                exp_off = expected_offsets.pop_front();
                if (o_offset_x !== exp_off.ox || o_offset_y !== exp_off.oy
                        || o_hit !== exp_off.hit) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d %0d hit %0b, got %0d %0d hit %0b",
                                 exp_off.ox, exp_off.oy, exp_off.hit,
                                 o_offset_x, o_offset_y, o_hit);
                end
            end
        end
    end

    // Send one beat, with random idle cycles before it at the current rate.
    // Valid stays high after the accepting edge so that beats can follow back
    // to back; it drops in the idle cycles and when the sender waits for the
    // pipeline to empty. The expectation is queued at the accepting edge,
    // using the frame time then in force.
    task automatic send_probe(t_probe p);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_pos_x <= p.px; i_pos_y <= p.py;
        i_vel_x <= p.vx; i_vel_y <= p.vy;
        i_wall_start_x <= p.w0x; i_wall_start_y <= p.w0y;
        i_wall_end_x <= p.w1x; i_wall_end_y <= p.w1y;
        do @(posedge i_clk); while (!o_ready);
        expected_offsets = {expected_offsets, predict_offset(p)};
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_offsets.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    // Change the frame time; the pipeline is drained first.
    task automatic write_frame_time(logic [TIME_W-1:0] t);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= t;
        do @(posedge i_clk); while (!o_cfg_ready);
        step_time = t;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(3))
            0: return 24'($urandom());
            1: return $signed(24'($urandom_range(8191))) - 24'sd4096;
            2: return 24'(1) <<< $urandom_range(23);
            default: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
        endcase
    endfunction

    function automatic t_probe random_probe();
        t_probe p;
        p.px = rand_coord(); p.py = rand_coord();
        p.vx = rand_coord(); p.vy = rand_coord();
        p.w0x = rand_coord(); p.w0y = rand_coord();
        p.w1x = rand_coord(); p.w1y = rand_coord();
        return p;
    endfunction

    // A probe built to cross the wall: the wall passes through a point on
    // the motion path, so most of these are hits.
    function automatic t_probe crossing_probe();
        t_probe p;
        longint mx, my, kx, ky;
        int     f;
        p.px = $signed(24'($urandom_range(65535))) - 24'sd32768;
        p.py = $signed(24'($urandom_range(65535))) - 24'sd32768;
        p.vx = $signed(24'($urandom())) >>> $urandom_range(8);
        p.vy = $signed(24'($urandom())) >>> $urandom_range(8);
        mx = motion_of(p.vx);
        my = motion_of(p.vy);
        f = $urandom_range(256);
        kx = longint'(p.px) + mx * f / 256;
        ky = longint'(p.py) + my * f / 256;
        p.w0x = sat_coord(kx - $urandom_range(20000));
        p.w0y = sat_coord(ky + $urandom_range(20000));
        p.w1x = sat_coord(2 * kx - longint'(p.w0x));
        p.w1y = sat_coord(2 * ky - longint'(p.w0y));
        return p;
    endfunction

    // Directed: field extremes, parallel and degenerate cases and touching
    // at the ends of both the motion and the wall.
    task automatic test_directed();
        t_probe p;
        write_frame_time(16'hffff);
        p = '{24'sh7fffff, 24'sh800000, 24'sh7fffff, 24'sh800000,
              24'sh800000, 24'sh7fffff, 24'sh7fffff, 24'sh800000};
        send_probe(p);
        p = '{24'sh800000, 24'sh7fffff, 24'sh800000, 24'sh7fffff,
              24'sh7fffff, 24'sh800000, 24'sh800000, 24'sh7fffff};
        send_probe(p);
        p = '{0, 0, 0, 0, 100, -100, 100, 100};   // zero motion
        send_probe(p);
        p = '{0, 0, 4096, 0, 100, 50, 100, 50};   // zero-length wall
        send_probe(p);
        p = '{0, 0, 4096, 0, 0, 100, 4096, 100};  // parallel
        send_probe(p);
        write_frame_time(16'h8000);
        // Motion of 2048 along x; the wall at x=1024 crosses halfway.
        p = '{0, 0, 4096, 0, 1024, -500, 1024, 500};
        send_probe(p);
        p = '{0, 0, 4096, 0, 2048, -500, 2048, 500};  // touches at motion end
        send_probe(p);
        p = '{0, 0, 4096, 0, 0, -500, 0, 500};        // touches at the start
        send_probe(p);
        p = '{0, 0, 4096, 0, 1024, 0, 1024, 500};     // wall end on the path
        send_probe(p);
        p = '{0, 0, 4096, 0, 1024, 1, 1024, 500};     // just misses
        send_probe(p);
        p = '{0, 0, -4096, -4096, -512, 0, 0, -512};  // negative motion
        send_probe(p);
        write_frame_time(16'h0000);
        p = '{0, 0, 24'sh7fffff, 24'sh7fffff, 1, -9, 1, 9};
        send_probe(p);
        write_frame_time(16'h0001);
        p = '{0, 0, 24'sh7fffff, 24'sh800000, 10, -200, 10, 200};
        send_probe(p);
    endtask

    task automatic test_random(int count, logic [TIME_W-1:0] t);
        write_frame_time(t);
        repeat (count) begin
            if ($urandom_range(99) < 70) send_probe(crossing_probe());
            else send_probe(random_probe());
        end
    endtask

    // Hold the result side for a long stretch while beats keep coming, so
    // the pipeline fills and drops o_ready.
    task automatic test_backpressure();
        write_frame_time(16'($urandom()));
        hold_cycles = 300;
        repeat (120) send_probe(crossing_probe());
        drain_results();
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        send_idle_pct = 32; take_idle_pct = 64;
        test_random(300, 16'h1000);
        test_random(300, 16'($urandom()));
        send_idle_pct = 64; take_idle_pct = 32;
        test_random(300, 16'hffff);
        test_random(300, 16'($urandom()));
        send_idle_pct = 0; take_idle_pct = 0;
        test_backpressure();
        test_random(300, 16'h0000);
        test_random(300, 16'($urandom()));
        drain_results();
        $display("Sent %0d beats over several frame times; %0d results, %0d hits.",
                 beats_sent, results_seen, hits_seen);
        if (mismatches == 0 && expected_offsets.size() == 0) begin
            $display("swept_segment_intersection_top test passed");
        end else begin
            $display("%0d mismatches, %0d results outstanding", mismatches,
                     expected_offsets.size());
            $display("swept_segment_intersection_top test failed");
        end
        $finish;
    end
endmodule
